// File: rtl/core/lcapd_pkg.sv
// ----------------------------------------------------------------------------
// lcapd_pkg
// Shared types and constants for the load cell presence detector.
// ----------------------------------------------------------------------------
package lcapd_pkg;

    localparam int SAMPLE_W  = 24;          // converter word
    localparam int SUM_W     = 28;          // group sum, up to 16 samples
    localparam int CNT_W     = 4;           // samples in current group
    localparam int GRP_W     = 5;           // group size, 1..16
    localparam int BIT_CNT_W = 5;           // bits shifted in
    localparam int RECIP_W   = 29;          // reciprocal for divide by group size
    localparam int PROD_W    = SUM_W + RECIP_W;

    localparam int MIN_SAMPLES = 1;
    localparam int MAX_SAMPLES = 16;

    localparam logic [BIT_CNT_W-1:0] BITS_PER_SAMPLE = 5'd24;
    localparam logic [SAMPLE_W-1:0]  SIGN_FLIP       = 24'h800000;
    localparam logic [SAMPLE_W-1:0]  THRESHOLD_RESET = 24'd50000;

    typedef enum logic [2:0] {
        PH_WAIT       = 3'd0,
        PH_HIGH       = 3'd1,
        PH_LOW        = 3'd2,
        PH_PULSE_HIGH = 3'd3,
        PH_PULSE_LOW  = 3'd4
    } t_phase;

    // serial front end -> averager, one set per tick
    typedef struct packed {
        logic                bit_last;     // last data bit shifted in this tick
        logic [SAMPLE_W-1:0] last_sample;  // offset-binary word formed this tick
        logic                done;         // conversion delivered this tick
        logic [SAMPLE_W-1:0] sample;       // delivered word, 0 when not done
    } t_rx_evt;

    // averager results for one tick
    typedef struct packed {
        logic                baseline_valid;
        logic [SAMPLE_W-1:0] baseline;
        logic                decision_valid;
        logic [SAMPLE_W-1:0] group_average;
        logic                item_present;
    } t_avg_res;

endpackage

// File: rtl/core/lcapd_serial_rx.sv
// ----------------------------------------------------------------------------
// lcapd_serial_rx
// Serial clock sequencer and 24-bit shift register for the converter link.
// ----------------------------------------------------------------------------
module lcapd_serial_rx (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_data_level,
    output logic                   o_clock_level,
    output lcapd_pkg::t_rx_evt     o_evt
);

    lcapd_pkg::t_phase                    r_phase, n_phase;
    logic [lcapd_pkg::BIT_CNT_W-1:0]      r_bit_count, n_bit_count;
    logic [lcapd_pkg::SAMPLE_W-1:0]       r_shift, n_shift;
    logic [lcapd_pkg::BIT_CNT_W-1:0]      w_bit_inc;
    logic [lcapd_pkg::SAMPLE_W-1:0]       w_shifted;
    logic                                 w_last;

    assign w_bit_inc = r_bit_count + 5'd1;
    assign w_shifted = {r_shift[lcapd_pkg::SAMPLE_W-2:0], i_data_level};
    assign w_last    = (w_bit_inc >= lcapd_pkg::BITS_PER_SAMPLE);

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        unique case (r_phase)
            lcapd_pkg::PH_HIGH: begin
                n_phase = lcapd_pkg::PH_LOW;
            end
            lcapd_pkg::PH_LOW: begin
                n_shift     = w_shifted;
                n_bit_count = w_bit_inc;
                n_phase     = w_last ? lcapd_pkg::PH_PULSE_HIGH : lcapd_pkg::PH_HIGH;
            end
            lcapd_pkg::PH_PULSE_HIGH: begin
                n_phase = lcapd_pkg::PH_PULSE_LOW;
            end
            lcapd_pkg::PH_PULSE_LOW: begin
                n_phase     = lcapd_pkg::PH_WAIT;
                n_bit_count = '0;
                n_shift     = '0;
            end
            default: begin
                n_phase     = i_data_level ? lcapd_pkg::PH_WAIT : lcapd_pkg::PH_HIGH;
                n_bit_count = '0;
                n_shift     = '0;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_clock_level     = 1'b0;
        o_evt.bit_last    = 1'b0;
        o_evt.last_sample = w_shifted ^ lcapd_pkg::SIGN_FLIP;
        o_evt.done        = 1'b0;
        o_evt.sample      = '0;
        unique case (r_phase)
            lcapd_pkg::PH_HIGH: begin
                o_clock_level = 1'b1;
            end
            lcapd_pkg::PH_LOW: begin
                o_evt.bit_last = w_last;
            end
            lcapd_pkg::PH_PULSE_HIGH: begin
                o_clock_level = 1'b1;
            end
            lcapd_pkg::PH_PULSE_LOW: begin
                o_evt.done   = 1'b1;
                o_evt.sample = r_shift ^ lcapd_pkg::SIGN_FLIP;
            end
            default: begin
                o_clock_level = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lcapd_pkg::PH_WAIT;
            r_bit_count <= '0;
            r_shift     <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
        end
    end

endmodule

// File: rtl/core/lcapd_averager.sv
// ----------------------------------------------------------------------------
// lcapd_averager
// Tare baseline, group averaging and threshold decision.
// ----------------------------------------------------------------------------
module lcapd_averager #(
    parameter int TARE_SAMPLES = 10,
    parameter int AVG_SAMPLES  = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  lcapd_pkg::t_rx_evt            i_evt,
    input  logic [lcapd_pkg::SAMPLE_W-1:0] i_threshold,
    output lcapd_pkg::t_avg_res           o_res
);

    // clamped group sizes
    localparam int TareN = (TARE_SAMPLES < lcapd_pkg::MIN_SAMPLES) ? lcapd_pkg::MIN_SAMPLES :
                           (TARE_SAMPLES > lcapd_pkg::MAX_SAMPLES) ? lcapd_pkg::MAX_SAMPLES :
                           TARE_SAMPLES;
    localparam int AvgN  = (AVG_SAMPLES < lcapd_pkg::MIN_SAMPLES) ? lcapd_pkg::MIN_SAMPLES :
                           (AVG_SAMPLES > lcapd_pkg::MAX_SAMPLES) ? lcapd_pkg::MAX_SAMPLES :
                           AVG_SAMPLES;

    // exact floor(sum / N) = (sum * ceil(2^(W+l) / N)) >> (W+l), l = clog2(N)
    localparam int TareShift = lcapd_pkg::SUM_W + $clog2(TareN);
    localparam int AvgShift  = lcapd_pkg::SUM_W + $clog2(AvgN);
    localparam logic [63:0] TareRecip64 =
        ((64'd1 << TareShift) + 64'(TareN) - 64'd1) / 64'(TareN);
    localparam logic [63:0] AvgRecip64 =
        ((64'd1 << AvgShift) + 64'(AvgN) - 64'd1) / 64'(AvgN);
    localparam logic [lcapd_pkg::RECIP_W-1:0] TareRecip = TareRecip64[lcapd_pkg::RECIP_W-1:0];
    localparam logic [lcapd_pkg::RECIP_W-1:0] AvgRecip  = AvgRecip64[lcapd_pkg::RECIP_W-1:0];
    localparam logic [lcapd_pkg::GRP_W-1:0]   TareCnt   = lcapd_pkg::GRP_W'(TareN);
    localparam logic [lcapd_pkg::GRP_W-1:0]   AvgCnt    = lcapd_pkg::GRP_W'(AvgN);

    logic [lcapd_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [lcapd_pkg::SUM_W-1:0]    r_sum_pend;       // sum including the newest sample
    logic [lcapd_pkg::PROD_W-1:0]   r_prod;
    logic [lcapd_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [lcapd_pkg::SAMPLE_W-1:0] r_baseline, n_baseline;
    logic                           r_tare_done, n_tare_done;
    logic                           r_present, n_present;

    logic [lcapd_pkg::RECIP_W-1:0]  w_recip;
    logic [lcapd_pkg::SAMPLE_W-1:0] w_quot;
    logic [lcapd_pkg::SAMPLE_W-1:0] w_diff;
    logic [lcapd_pkg::GRP_W-1:0]    w_cnt_inc;
    logic [lcapd_pkg::GRP_W-1:0]    w_grp;
    logic                           w_complete;
    logic                           w_decision;

    assign w_recip   = r_tare_done ? AvgRecip : TareRecip;
    assign w_quot    = r_tare_done ? lcapd_pkg::SAMPLE_W'(r_prod >> AvgShift)
                                   : lcapd_pkg::SAMPLE_W'(r_prod >> TareShift);
    assign w_diff    = (w_quot > r_baseline) ? (w_quot - r_baseline) : (r_baseline - w_quot);
    assign w_cnt_inc = {1'b0, r_cnt} + 5'd1;
    assign w_grp     = r_tare_done ? AvgCnt : TareCnt;
    assign w_complete = (w_cnt_inc >= w_grp);

    always_comb begin
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_baseline  = r_baseline;
        n_tare_done = r_tare_done;
        n_present   = r_present;
        w_decision  = 1'b0;
        if (i_evt.done) begin
            if (w_complete) begin
                n_sum = '0;
                n_cnt = '0;
                if (!r_tare_done) begin
                    n_baseline  = w_quot;
                    n_tare_done = 1'b1;
                end else begin
                    n_present  = (w_diff > i_threshold);
                    w_decision = 1'b1;
                end
            end else begin
                n_sum = r_sum_pend;
                n_cnt = w_cnt_inc[lcapd_pkg::CNT_W-1:0];
            end
        end
    end

    always_comb begin
        o_res.baseline_valid = n_tare_done;
        o_res.baseline       = n_tare_done ? n_baseline : '0;
        o_res.decision_valid = w_decision;
        o_res.group_average  = w_decision ? w_quot : '0;
        o_res.item_present   = n_present;
    end

    // sum is formed on the last bit tick, multiplied during the pulse-high
    // tick, and the quotient is used on the pulse-low tick
    always_ff @(posedge i_clk) begin
        if (i_accept && i_evt.bit_last) begin
            r_sum_pend <= r_sum + lcapd_pkg::SUM_W'(i_evt.last_sample);
        end
        r_prod <= lcapd_pkg::PROD_W'(r_sum_pend) * lcapd_pkg::PROD_W'(w_recip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_baseline  <= '0;
            r_tare_done <= 1'b0;
            r_present   <= 1'b0;
        end else if (i_accept) begin
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_baseline  <= n_baseline;
            r_tare_done <= n_tare_done;
            r_present   <= n_present;
        end
    end

endmodule

// File: rtl/core/load_cell_adc_presence_detector_top.sv
// ----------------------------------------------------------------------------
// load_cell_adc_presence_detector_top
// Serial readout of a 24-bit load cell converter with tare and presence test.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid / o_stall): one beat per half-clock tick of the
//    converter link, carrying the sampled data-out level in i_data_level.
//  - Output channel (o_valid / i_stall): one beat per input beat, giving the
//    serial clock level to drive for that tick plus sample, baseline and
//    presence status.
//  - Each result is registered and appears in the cycle after input acceptance.
//    Throughput is one beat per cycle while the receiver does not stall; the
//    group divide spans the two pulse ticks after the last bit and holds no tick.
//  - A stalled result stays in the output register; the input stalls only
//    while that register is full and the receiver stalls.
//  - i_cfg_wr_en / i_cfg_wr_data write the presence threshold; write it only
//    while the block is idle.
//  - Reset (synchronous, active low) returns the link to waiting for
//    data-out low, clears the tare, the group sum and the presence flag, and
//    sets the threshold to 50000.
// ----------------------------------------------------------------------------
module load_cell_adc_presence_detector_top #(
    parameter int TARE_SAMPLES = 10,
    parameter int AVG_SAMPLES  = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // tick input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_data_level,

    // threshold register
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data,

    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_clock_level,
    output logic        o_sample_valid,
    output logic [23:0] o_sample_value,
    output logic        o_baseline_valid,
    output logic [23:0] o_baseline,
    output logic        o_decision_valid,
    output logic [23:0] o_group_average,
    output logic        o_item_present
);

    logic                           w_accept;
    logic                           w_clock_level;
    lcapd_pkg::t_rx_evt             w_evt;
    lcapd_pkg::t_avg_res            w_res;

    logic [lcapd_pkg::SAMPLE_W-1:0] r_threshold;
    logic                           r_out_valid;
    logic                           r_clock_level;
    logic                           r_sample_valid;
    logic [lcapd_pkg::SAMPLE_W-1:0] r_sample_value;
    lcapd_pkg::t_avg_res            r_res;

    // input is held off only when a result is waiting and cannot leave
    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= lcapd_pkg::THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    lcapd_serial_rx u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_level  (i_data_level),
        .o_clock_level (w_clock_level),
        .o_evt         (w_evt)
    );

    lcapd_averager #(
        .TARE_SAMPLES (TARE_SAMPLES),
        .AVG_SAMPLES  (AVG_SAMPLES)
    ) u_avg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_evt       (w_evt),
        .i_threshold (r_threshold),
        .o_res       (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_clock_level  <= w_clock_level;
            r_sample_valid <= w_evt.done;
            r_sample_value <= w_evt.sample;
            r_res          <= w_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_clock_level    = r_clock_level;
    assign o_sample_valid   = r_sample_valid;
    assign o_sample_value   = r_sample_value;
    assign o_baseline_valid = r_res.baseline_valid;
    assign o_baseline       = r_res.baseline;
    assign o_decision_valid = r_res.decision_valid;
    assign o_group_average  = r_res.group_average;
    assign o_item_present   = r_res.item_present;

endmodule
